FILE: rtl/core/plt_pkg.sv
// Package for the piecewise-linear table interpolation unit.
// Holds sequencer states, walk steps, request kinds and status codes.
// No dependencies.
package plt_pkg;

  localparam int SNR_W  = 16;
  localparam int RATE_W = 17;
  localparam int PROD_W = 2 * RATE_W;

  localparam logic signed [SNR_W-1:0] SNR_START = 16'sh9C00;
  localparam logic [RATE_W-1:0]       RATE_ONE  = 17'h10000;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_FORWARD = 2'd2,
    KIND_INVERSE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNSORTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FEW      = 3'd3,
    ST_HIGH     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_MUL, S_DIVGO, S_DIV, S_FIN, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    P_APPEND, P_F_FIRST, P_F_WALK, P_I_LAST, P_I_ONE, P_I_WALK
  } step_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

FILE: rtl/core/plt_if.sv
// Request and result channel interfaces for the interpolation unit.
// Depends on plt_pkg for field widths.
interface plt_in_if import plt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [SNR_W-1:0]  snr_value;
  logic [RATE_W-1:0]        rate_value;
  modport source (output valid, kind, snr_value, rate_value, input ready);
  modport sink   (input valid, kind, snr_value, rate_value, output ready);
endinterface

interface plt_out_if import plt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [RATE_W-1:0]        rate_out;
  logic signed [SNR_W-1:0]  snr_out;
  logic [2:0]               status;
  modport source (output valid, rate_out, snr_out, status, input ready);
  modport sink   (input valid, rate_out, snr_out, status, output ready);
endinterface

FILE: rtl/core/plt_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on plt_pkg.
module plt_div import plt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic              done,
  output logic [RATE_W-1:0] quotient
);
  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] acc;
  logic [RATE_W:0]   rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [RATE_W:0]   rem_sh;
  logic [RATE_W:0]   rem_sub;
  logic              fits;

  assign rem_sh  = {rem[RATE_W-1:0], acc[PROD_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quotient = acc[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROD_W);
        acc  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? rem_sub : rem_sh;
        acc <= {acc[PROD_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/core/piecewise_linear_table_interp_unit.sv
// Top level of the piecewise-linear SNR / error rate table unit.
// Depends on plt_pkg, plt_in_if, plt_out_if and plt_div.
//
// channel  | dir | payload
// in_req   | in  | kind, snr_value, rate_value
// out_res  | out | rate_out, snr_out, status
//
// One request at a time. Clear and most errors go straight to the output step;
// append first reads the last entry. A lookup walks the table one entry at a time
// (one registered memory read port, read then check), then a serial divide.
// Reset empties the table; no clearing pass. A stalled result holds the
// sequencer in its output step while one result waits in the output register.
module piecewise_linear_table_interp_unit import plt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  plt_in_if.sink     in_req,
  plt_out_if.source  out_res
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [SNR_W+RATE_W-1:0] mem [TABLE_DEPTH];
  logic [SNR_W+RATE_W-1:0] rd_data;

  state_t state, state_next;
  step_t  step, step_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  logic [1:0] kind_q;
  logic signed [SNR_W-1:0] snr_q;
  logic [RATE_W-1:0] rate_q;
  logic signed [SNR_W-1:0] prev_snr, prev_snr_next;
  logic [RATE_W-1:0] prev_rate, prev_rate_next;
  logic [RATE_W-1:0] op_a, op_a_next, op_b, op_b_next, op_d, op_d_next;
  logic [PROD_W-1:0] prod;
  logic [RATE_W-1:0] res_rate, res_rate_next;
  logic signed [SNR_W-1:0] res_snr, res_snr_next;
  status_t res_status, res_status_next;
  logic wr_en;
  logic accept;
  div_ctl_t div_ctl;
  logic [RATE_W-1:0] quot;

  logic signed [SNR_W-1:0] d_snr;
  logic [RATE_W-1:0] d_rate;
  logic signed [SNR_W-1:0] last_snr;
  logic [RATE_W-1:0] last_rate;
  logic [SNR_W:0] dx_snr, span_snr, dy_snr;
  logic [CW-1:0] idx_inc;

  assign d_snr    = rd_data[SNR_W+RATE_W-1:RATE_W];
  assign d_rate   = rd_data[RATE_W-1:0];
  // empty table: compare against the start point
  assign last_snr  = (count == '0) ? SNR_START : d_snr;
  assign last_rate = (count == '0) ? RATE_ONE : d_rate;
  assign dx_snr   = {snr_q[SNR_W-1], snr_q} - {prev_snr[SNR_W-1], prev_snr};
  assign span_snr = {d_snr[SNR_W-1], d_snr} - {prev_snr[SNR_W-1], prev_snr};
  assign dy_snr   = span_snr;
  assign idx_inc  = CW'(idx) + 1'b1;

  assign in_req.ready  = (state == S_IDLE);
  assign accept        = in_req.valid && in_req.ready;
  assign div_ctl.start = (state == S_DIVGO);

  plt_div u_div (
    .clk(clk), .rst(rst), .start(div_ctl.start), .dividend(prod), .divisor(op_d),
    .done(div_ctl.done), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
    if (wr_en) mem[count[AW-1:0]] <= {snr_q, rate_q};
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    idx_next        = idx;
    count_next      = count;
    prev_snr_next   = prev_snr;
    prev_rate_next  = prev_rate;
    op_a_next       = op_a;
    op_b_next       = op_b;
    op_d_next       = op_d;
    res_rate_next   = res_rate;
    res_snr_next    = res_snr;
    res_status_next = res_status;
    wr_en           = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_rate_next   = '0;
          res_snr_next    = '0;
          res_status_next = ST_OK;
          state_next      = S_OUT;
          unique case (kind_t'(in_req.kind))
            KIND_CLEAR: count_next = '0;
            KIND_APPEND: begin
              if (count >= CW'(TABLE_DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                idx_next   = (count == '0) ? '0 : AW'(count - 1'b1);
                step_next  = P_APPEND;
                state_next = S_RD;
              end
            end
            KIND_FORWARD: begin
              if (count == '0) begin
                res_status_next = ST_FEW;
              end else begin
                idx_next   = '0;
                step_next  = P_F_FIRST;
                state_next = S_RD;
              end
            end
            default: begin
              if (count < CW'(2)) begin
                res_status_next = ST_FEW;
              end else begin
                idx_next   = AW'(count - 1'b1);
                step_next  = P_I_LAST;
                state_next = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        state_next = S_OUT;
        unique case (step)
          P_APPEND: begin
            if (snr_q <= last_snr || rate_q > last_rate) res_status_next = ST_UNSORTED;
            else wr_en = 1'b1;
          end
          P_F_FIRST: begin
            prev_snr_next  = d_snr;
            prev_rate_next = d_rate;
            if (snr_q < d_snr) begin
              res_rate_next = RATE_ONE;
            end else if (count != CW'(1)) begin
              idx_next   = AW'(1);
              step_next  = P_F_WALK;
              state_next = S_RD;
            end
          end
          P_F_WALK: begin
            if (snr_q > d_snr) begin
              prev_snr_next  = d_snr;
              prev_rate_next = d_rate;
              if (idx_inc < count) begin
                idx_next   = AW'(idx_inc);
                state_next = S_RD;
              end
            end else begin
              op_a_next  = dx_snr;
              op_b_next  = prev_rate - d_rate;
              op_d_next  = span_snr;
              state_next = S_MUL;
            end
          end
          P_I_LAST: begin
            if (rate_q < d_rate) begin
              res_snr_next = d_snr;
            end else begin
              idx_next   = AW'(1);
              step_next  = P_I_ONE;
              state_next = S_RD;
            end
          end
          P_I_ONE: begin
            if (rate_q > d_rate) begin
              res_status_next = ST_HIGH;
            end else if (rate_q == d_rate) begin
              res_snr_next = d_snr;
            end else begin
              prev_snr_next  = d_snr;
              prev_rate_next = d_rate;
              idx_next       = AW'(idx_inc);
              step_next      = P_I_WALK;
              state_next     = S_RD;
            end
          end
          default: begin
            if (rate_q == d_rate) begin
              res_snr_next = d_snr;
            end else if (rate_q > d_rate) begin
              op_a_next  = prev_rate - rate_q;
              op_b_next  = dy_snr;
              op_d_next  = prev_rate - d_rate;
              state_next = S_MUL;
            end else begin
              prev_snr_next  = d_snr;
              prev_rate_next = d_rate;
              idx_next       = AW'(idx_inc);
              state_next     = S_RD;
            end
          end
        endcase
      end
      S_MUL:   state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIV;
      S_DIV:   if (div_ctl.done) state_next = S_FIN;
      S_FIN: begin
        if (kind_q == KIND_FORWARD) res_rate_next = prev_rate - quot;
        else res_snr_next = prev_snr + $signed(quot[SNR_W-1:0]);
        state_next = S_OUT;
      end
      default: begin
        if (!out_res.valid || out_res.ready) state_next = S_IDLE;
      end
    endcase
    if (wr_en) count_next = count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      out_res.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      out_res.valid <= (state == S_OUT && (!out_res.valid || out_res.ready)) ||
                       (out_res.valid && !out_res.ready);
    end
  end

  always_ff @(posedge clk) begin
    step       <= step_next;
    idx        <= idx_next;
    prev_snr   <= prev_snr_next;
    prev_rate  <= prev_rate_next;
    op_a       <= op_a_next;
    op_b       <= op_b_next;
    op_d       <= op_d_next;
    res_rate   <= res_rate_next;
    res_snr    <= res_snr_next;
    res_status <= res_status_next;
    if (state == S_MUL) prod <= op_a * op_b;
    if (accept) begin
      kind_q <= in_req.kind;
      snr_q  <= in_req.snr_value;
      rate_q <= in_req.rate_value;
    end
    if (state == S_OUT && (!out_res.valid || out_res.ready)) begin
      out_res.rate_out <= res_rate;
      out_res.snr_out  <= res_snr;
      out_res.status   <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("entry count above table depth");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && in_req.kind == KIND_CLEAR |=> count == '0)
    else $error("clear did not empty table");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_ctl.done) else $error("divider finished while idle");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> count < CW'(TABLE_DEPTH)) else $error("write into full table");

endmodule

FILE: sim/plt_tb_if.sv
// Testbench constants shared by the bench top.
// No dependencies; the request and result interfaces come from rtl/core/plt_if.sv.
package plt_tb_defs;
  localparam int TABLE_DEPTH = 64;
endpackage

FILE: sim/tb_piecewise_linear_table_interp_unit.sv
// Testbench for piecewise_linear_table_interp_unit: table builds, forward and inverse
// lookups checked against an in-bench table predictor. Depends on plt_pkg, plt_if, plt_tb_defs.
module tb_piecewise_linear_table_interp_unit;
  import plt_pkg::*;
  import plt_tb_defs::*;

  typedef struct packed {
    logic [RATE_W-1:0]       rate;
    logic signed [SNR_W-1:0] snr;
    logic [2:0]              status;
  } lookup_res_t;

  logic clk = 0;
  logic rst = 1;
  int   fails = 0;
  bit   idle_in = 1, idle_out = 1;

  plt_in_if  in_req();
  plt_out_if out_res();

  piecewise_linear_table_interp_unit #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
    .clk(clk), .rst(rst), .in_req(in_req), .out_res(out_res)
  );

  initial forever #10 clk = ~clk;

  integer            tbl_snr [TABLE_DEPTH];
  integer            tbl_rate[TABLE_DEPTH];
  int                tbl_n = 0;
  lookup_res_t       expected_q[$];

  function automatic longint interp(longint x, longint x0, longint x1, longint y0,
                                    longint y1);
    longint den;
    den = x1 - x0;
    if (den == 0) return y0;
    return y0 + ((x - x0) * (y1 - y0)) / den;
  endfunction

  function automatic lookup_res_t predict_lookup(kind_t k, integer snr, integer rate);
    lookup_res_t r;
    longint rr, sr;
    status_t st;
    integer ls, lr;
    int i;
    rr = 0; sr = 0; st = ST_OK;
    case (k)
      KIND_CLEAR: tbl_n = 0;
      KIND_APPEND: begin
        ls = -25600; lr = 65536;
        if (tbl_n > 0) begin
          ls = tbl_snr[tbl_n-1]; lr = tbl_rate[tbl_n-1];
        end
        if (tbl_n >= TABLE_DEPTH) st = ST_FULL;
        else if (snr <= ls || rate > lr) st = ST_UNSORTED;
        else begin
          tbl_snr[tbl_n] = snr; tbl_rate[tbl_n] = rate; tbl_n++;
        end
      end
      KIND_FORWARD: begin
        if (tbl_n == 0) st = ST_FEW;
        else if (snr < tbl_snr[0]) rr = 65536;
        else begin
          i = 1;
          while (i < tbl_n && snr > tbl_snr[i]) i++;
          if (i >= tbl_n) rr = 0;
          else rr = interp(snr, tbl_snr[i-1], tbl_snr[i], tbl_rate[i-1], tbl_rate[i]);
        end
      end
      default: begin
        if (tbl_n < 2) st = ST_FEW;
        else if (rate < tbl_rate[tbl_n-1]) sr = tbl_snr[tbl_n-1];
        else if (rate > tbl_rate[1]) st = ST_HIGH;
        else begin
          sr = tbl_snr[tbl_n-1];
          for (i = 1; i < tbl_n; i++)
            if (rate >= tbl_rate[i]) begin
              if (rate == tbl_rate[i]) sr = tbl_snr[i];
              else sr = interp(rate, tbl_rate[i-1], tbl_rate[i], tbl_snr[i-1], tbl_snr[i]);
              break;
            end
        end
      end
    endcase
    if (st != ST_OK) begin
      rr = 0; sr = 0;
    end
    r.rate = rr[RATE_W-1:0];
    r.snr = sr[SNR_W-1:0];
    r.status = st;
    return r;
  endfunction

  task automatic send_request(kind_t k, integer snr, integer rate);
    lookup_res_t e;
    while (idle_in && $urandom_range(99) < 26) begin
      in_req.valid <= 0;
      @(negedge clk);
    end
    in_req.valid <= 1;
    in_req.kind <= k;
    in_req.snr_value <= snr[SNR_W-1:0];
    in_req.rate_value <= rate[RATE_W-1:0];
    do @(posedge clk); while (!in_req.ready);
    e = predict_lookup(k, $signed(snr[SNR_W-1:0]), rate[RATE_W-1:0]);
    expected_q.insert(expected_q.size(), e);
    @(negedge clk);
  endtask

  always @(negedge clk)
    out_res.ready <= rst ? 1'b0 : !(idle_out && $urandom_range(99) < 26);

  always @(posedge clk) begin
    lookup_res_t e;
    if (!rst && out_res.valid && out_res.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result rate=%0d snr=%0d status=%0d", $time,
                 out_res.rate_out, out_res.snr_out, out_res.status);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (e.rate !== out_res.rate_out || e.snr !== out_res.snr_out ||
            e.status !== out_res.status) begin
          $display("%0t mismatch exp rate=%0d snr=%0d status=%0d act rate=%0d snr=%0d status=%0d",
                   $time, e.rate, e.snr, e.status, out_res.rate_out, out_res.snr_out,
                   out_res.status);
          fails++;
        end
      end
    end
  end

  // Build a sorted table of n points with random spacing.
  task automatic build_table(int n);
    integer s, r;
    send_request(KIND_CLEAR, 0, 0);
    s = -25600 + $urandom_range(1, 2000);
    r = $urandom_range(30000, 65536);
    for (int i = 0; i < n; i++) begin
      send_request(KIND_APPEND, s, r);
      s += $urandom_range(1, 800);
      if (s > 32767) s = 32767;
      r -= $urandom_range(0, 2000);
      if (r < 0) r = 0;
    end
  endtask

  task automatic test_directed();
    send_request(KIND_FORWARD, 0, 0);
    send_request(KIND_INVERSE, 0, 0);
    send_request(KIND_APPEND, -25600, 65536);
    send_request(KIND_APPEND, -32768, 1000);
    send_request(KIND_APPEND, 0, 131071);
    send_request(KIND_APPEND, -25599, 65536);
    send_request(KIND_INVERSE, 0, 0);
    send_request(KIND_APPEND, 100, 40000);
    send_request(KIND_APPEND, 32767, 0);
    send_request(KIND_FORWARD, -32768, 0);
    send_request(KIND_FORWARD, 32767, 0);
    send_request(KIND_FORWARD, 100, 0);
    send_request(KIND_FORWARD, -100, 0);
    send_request(KIND_INVERSE, 0, 131071);
    send_request(KIND_INVERSE, 0, 40000);
    send_request(KIND_INVERSE, 0, 20000);
    send_request(KIND_INVERSE, 0, 0);
    send_request(KIND_APPEND, 32767, 0);
    send_request(KIND_CLEAR, -1, 131071);
  endtask

  task automatic test_full_table();
    build_table(TABLE_DEPTH);
    send_request(KIND_APPEND, 32767, 0);
    send_request(KIND_FORWARD, tbl_snr[TABLE_DEPTH-1] - 1, 0);
    send_request(KIND_INVERSE, 0, tbl_rate[TABLE_DEPTH-1]);
  endtask

  task automatic test_random(int items);
    int sent, n;
    integer s, r;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(0, 12);
      build_table(n);
      sent += n + 1;
      repeat ($urandom_range(5, 20)) begin
        if (tbl_n > 0 && $urandom_range(3) != 0)
          s = tbl_snr[$urandom_range(tbl_n-1)] + int'($urandom_range(0, 600)) - 300;
        else
          s = $signed(16'($urandom));
        if (tbl_n > 0 && $urandom_range(3) != 0)
          r = tbl_rate[$urandom_range(tbl_n-1)] + int'($urandom_range(0, 600)) - 300;
        else
          r = $urandom_range(0, 131071);
        if (r < 0) r = 0;
        if (s > 32767) s = 32767;
        send_request(kind_t'($urandom_range(1, 3)), s, r);
        sent++;
      end
      if (sent > items / 2 && sent < items / 2 + 40) idle_in = 0;
      else idle_in = 1;
      idle_out = idle_in;
    end
  endtask

  initial begin
    in_req.valid = 0;
    in_req.kind = KIND_CLEAR;
    in_req.snr_value = 0;
    in_req.rate_value = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_full_table();
    test_random(1500);
    in_req.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("tb_piecewise_linear_table_interp_unit OK");
    else $display("tb_piecewise_linear_table_interp_unit NOT OK");
    $finish;
  end

  initial begin
    #100000000;
    $display("tb_piecewise_linear_table_interp_unit NOT OK");
    $finish;
  end

endmodule

FILE: piecewise_linear_table_interp_unit.f
rtl/core/plt_pkg.sv
rtl/core/plt_if.sv
rtl/core/plt_div.sv
rtl/core/piecewise_linear_table_interp_unit.sv
sim/plt_tb_if.sv
sim/tb_piecewise_linear_table_interp_unit.sv
